// ===== src/soc_pkg.sv =====
package soc_pkg;

  // Fixed field widths.
  localparam int unsigned PressureW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned DelayW    = 14;
  localparam int unsigned PowerOnW  = 8;
  localparam int unsigned OnOffW    = 20;
  localparam int unsigned StartW    = 24;

  // Timing constants: tick period in ms, ms per tenth second and per minute.
  localparam int unsigned TickMs   = 10;
  localparam int unsigned TenthMs  = 100;
  localparam int unsigned MinuteMs = 60000;

  // Products used for the delay checks, wide enough to never overflow.
  localparam int unsigned OnOffProdW = OnOffW + 8;
  localparam int unsigned StartProdW = StartW + 8;

  // Window margin, in units of the pressure value.
  localparam int unsigned WindowMargin = 100;

  // Register indexes of the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    RegOutputMode   = 3'd0,
    RegWindowMode   = 3'd1,
    RegOutputType   = 3'd2,
    RegPointOne     = 3'd3,
    RegPointTwo     = 3'd4,
    RegOnDelay      = 3'd5,
    RegOffDelay     = 3'd6,
    RegPowerOnDelay = 3'd7
  } reg_idx_e;

  // Output mode codes.
  typedef enum logic [1:0] {
    OutOff      = 2'd0,
    OutDisabled = 2'd1,
    OutNc       = 2'd2,
    OutNo       = 2'd3
  } out_mode_e;

  // Output type codes.
  typedef enum logic {
    TypePnp = 1'b0,
    TypeNpn = 1'b1
  } out_type_e;

  typedef struct packed {
    out_mode_e                    output_mode;
    logic                         window_mode;
    out_type_e                    pin_sel;
    logic signed [PressureW-1:0]  point_one;
    logic signed [PressureW-1:0]  point_two;
    logic [DelayW-1:0]            rise_delay;
    logic [DelayW-1:0]            fall_delay;
    logic [PowerOnW-1:0]          startup_delay;
  } cfg_t;

  typedef struct packed {
    logic              raw_state;
    logic              qual_state;
    logic [OnOffW-1:0] on_ticks;
    logic [OnOffW-1:0] off_ticks;
    logic [StartW-1:0] startup_ticks;
    logic              startup_armed;
    logic              active_state;
    logic              pnp_level;
    logic              npn_level;
  } state_t;

  typedef struct packed {
    logic pnp_drive;
    logic npn_drive;
    logic switch_active;
    logic raw_switch;
    logic raw_toggle;
    logic power_on_done;
  } result_t;

endpackage

// ===== src/soc_eval.sv =====
module soc_eval (
  input  soc_pkg::cfg_t                        cfg_i,
  input  soc_pkg::state_t                      state_i,
  input  logic signed [soc_pkg::PressureW-1:0] pressure_i,
  output soc_pkg::state_t                      state_o,
  output soc_pkg::result_t                     result_o
);

  logic                               mode_off;
  logic                               raw;
  logic signed [soc_pkg::PressureW:0] x_ext;
  logic signed [soc_pkg::PressureW:0] hi_margin;
  logic signed [soc_pkg::PressureW:0] lo_margin;
  logic signed [soc_pkg::PressureW:0] p1_ext;
  logic signed [soc_pkg::PressureW:0] p2_ext;
  logic [soc_pkg::OnOffProdW-1:0]     on_elapsed;
  logic [soc_pkg::OnOffProdW-1:0]     off_elapsed;
  logic [soc_pkg::OnOffProdW-1:0]     on_limit;
  logic [soc_pkg::OnOffProdW-1:0]     off_limit;
  logic [soc_pkg::StartProdW-1:0]     start_elapsed;
  logic [soc_pkg::StartProdW-1:0]     start_limit;
  logic                               started;
  logic                               delayed;
  logic                               active;

  // Output modes zero and one both mean the output is switched off.
  always_comb begin
    case (cfg_i.output_mode) inside
      soc_pkg::OutNc, soc_pkg::OutNo: mode_off = 1'b0;
      default:                        mode_off = 1'b1;
    endcase
  end

  // Margins are formed one bit wider than the points so they never wrap.
  assign x_ext     = {pressure_i[soc_pkg::PressureW-1], pressure_i};
  assign p1_ext    = {cfg_i.point_one[soc_pkg::PressureW-1], cfg_i.point_one};
  assign p2_ext    = {cfg_i.point_two[soc_pkg::PressureW-1], cfg_i.point_two};
  assign hi_margin = p1_ext - (soc_pkg::PressureW+1)'(soc_pkg::WindowMargin);
  assign lo_margin = p2_ext + (soc_pkg::PressureW+1)'(soc_pkg::WindowMargin);

  // Raw comparison; each later test overrides the earlier ones.
  always_comb begin
    raw = state_i.raw_state;
    if (!cfg_i.window_mode) begin
      if (mode_off) begin
        raw = 1'b0;
      end else if (cfg_i.point_one < cfg_i.point_two) begin
        if (cfg_i.point_one > pressure_i) raw = 1'b1;
        if (cfg_i.point_two < pressure_i) raw = 1'b0;
      end else if (cfg_i.point_one > cfg_i.point_two) begin
        if (cfg_i.point_one < pressure_i) raw = 1'b1;
        if (cfg_i.point_two > pressure_i) raw = 1'b0;
      end
    end else if (!mode_off) begin
      if (lo_margin < x_ext) raw = 1'b0;
      if (p1_ext < x_ext)    raw = 1'b1;
      if (hi_margin > x_ext) raw = 1'b0;
      if (p2_ext > x_ext)    raw = 1'b1;
    end
  end

  // Delay checks compare elapsed milliseconds against the delay in ms,
  // which is the same as comparing the truncated quotient with the delay.
  assign on_elapsed  = soc_pkg::OnOffProdW'(state_i.on_ticks) *
                       soc_pkg::OnOffProdW'(soc_pkg::TickMs);
  assign off_elapsed = soc_pkg::OnOffProdW'(state_i.off_ticks) *
                       soc_pkg::OnOffProdW'(soc_pkg::TickMs);
  assign on_limit    = soc_pkg::OnOffProdW'(cfg_i.rise_delay) *
                       soc_pkg::OnOffProdW'(soc_pkg::TenthMs);
  assign off_limit   = soc_pkg::OnOffProdW'(cfg_i.fall_delay) *
                       soc_pkg::OnOffProdW'(soc_pkg::TenthMs);
  assign start_elapsed = soc_pkg::StartProdW'(state_i.startup_ticks) *
                         soc_pkg::StartProdW'(soc_pkg::TickMs);
  assign start_limit   = soc_pkg::StartProdW'(cfg_i.startup_delay) *
                         soc_pkg::StartProdW'(soc_pkg::MinuteMs);
  assign started       = (start_elapsed >= start_limit);

  // Qualified state after the on-delay and off-delay.
  always_comb begin
    delayed = state_i.qual_state;
    if (raw && (on_elapsed >= on_limit)) delayed = 1'b1;
    if (!raw && (off_elapsed >= off_limit)) delayed = 1'b0;
  end

  // Normally closed inverts, normally open passes, off and disabled force inactive.
  always_comb begin
    case (cfg_i.output_mode)
      soc_pkg::OutNc: active = ~delayed;
      soc_pkg::OutNo: active = delayed;
      default:        active = 1'b0;
    endcase
  end

  // Next state and result word.
  always_comb begin
    state_o = state_i;
    state_o.raw_state = raw;
    result_o.power_on_done = 1'b0;
    if (started) begin
      state_o.startup_armed = 1'b0;
      result_o.power_on_done = state_i.startup_armed;
      state_o.qual_state = delayed;
      // Counters run only while the delay is still pending, and saturate.
      if (raw) begin
        state_o.off_ticks = '0;
        if ((on_elapsed < on_limit) && (state_i.on_ticks != '1)) begin
          state_o.on_ticks = state_i.on_ticks + 1'b1;
        end
      end else begin
        state_o.on_ticks = '0;
        if ((off_elapsed < off_limit) && (state_i.off_ticks != '1)) begin
          state_o.off_ticks = state_i.off_ticks + 1'b1;
        end
      end
      state_o.active_state = active;
      // The selected pin follows; the other pin drops only on activation.
      if (active) begin
        state_o.pnp_level = (cfg_i.pin_sel == soc_pkg::TypePnp);
        state_o.npn_level = (cfg_i.pin_sel == soc_pkg::TypeNpn);
      end else if (cfg_i.pin_sel == soc_pkg::TypePnp) begin
        state_o.pnp_level = 1'b0;
      end else begin
        state_o.npn_level = 1'b0;
      end
    end else begin
      state_o.startup_armed = 1'b1;
      if (state_i.startup_ticks != '1) begin
        state_o.startup_ticks = state_i.startup_ticks + 1'b1;
      end
    end
    result_o.pnp_drive     = state_o.pnp_level;
    result_o.npn_drive     = state_o.npn_level;
    result_o.switch_active = state_o.active_state;
    result_o.raw_switch    = raw;
    result_o.raw_toggle    = (raw != state_i.raw_state);
  end

endmodule

// ===== src/switch_output_comparator_core.sv =====
// Switching-output comparator, one channel.
// Input channel: one word per control tick carrying a signed pressure value,
// handshaked with in_valid_i / in_ready_o. Output channel: one result word per
// tick (pin levels, qualified and raw switch state, change and power-on-done
// pulses), handshaked with out_valid_o / out_ready_i.
// Configuration: write cfg_wdata_i to register cfg_addr_i while cfg_we_i is
// high; only while no word is in flight.
// A word accepted into the input register is evaluated and its result is
// loaded into the result register once that register is free.
// Throughput: one word per cycle while the receiver takes results; the
// comparison, delay checks and output drive all settle between the input
// register and the result register, and the tick state moves once per word.
// The input register keeps accepting while a result waits, as long as it
// can move forward; when the receiver stalls, at most two words are held and
// in_ready_o drops until the result is taken.
// Reset clears all configuration to zero, all tick counters and output
// levels, and empties both register stages.
module switch_output_comparator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [soc_pkg::CfgAddrW-1:0]         cfg_addr_i,
  input  logic [soc_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [soc_pkg::PressureW-1:0] pressure_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 pnp_drive_o,
  output logic                                 npn_drive_o,
  output logic                                 switch_active_o,
  output logic                                 raw_switch_o,
  output logic                                 raw_toggle_o,
  output logic                                 power_on_done_o
);

  soc_pkg::cfg_t                        cfg_q, cfg_d;
  soc_pkg::state_t                      state_q, state_d;
  soc_pkg::result_t                     result_q, result_d;
  logic signed [soc_pkg::PressureW-1:0] pressure_q;
  logic                                 in_valid_q;
  logic                                 out_valid_q;
  logic                                 advance;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (soc_pkg::reg_idx_e'(cfg_addr_i))
        soc_pkg::RegOutputMode:   cfg_d.output_mode = soc_pkg::out_mode_e'(cfg_wdata_i[1:0]);
        soc_pkg::RegWindowMode:   cfg_d.window_mode = cfg_wdata_i[0];
        soc_pkg::RegOutputType:   cfg_d.pin_sel = soc_pkg::out_type_e'(cfg_wdata_i[0]);
        soc_pkg::RegPointOne:     cfg_d.point_one = cfg_wdata_i;
        soc_pkg::RegPointTwo:     cfg_d.point_two = cfg_wdata_i;
        soc_pkg::RegOnDelay:      cfg_d.rise_delay = cfg_wdata_i[soc_pkg::DelayW-1:0];
        soc_pkg::RegOffDelay:     cfg_d.fall_delay = cfg_wdata_i[soc_pkg::DelayW-1:0];
        soc_pkg::RegPowerOnDelay: cfg_d.startup_delay = cfg_wdata_i[soc_pkg::PowerOnW-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A word moves from the input register to the result register when the
  // result register is empty or its word is being taken.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  soc_eval u_eval (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .pressure_i (pressure_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  // Handshake and tick state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      pressure_q <= pressure_value_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pnp_drive_o     = result_q.pnp_drive;
  assign npn_drive_o     = result_q.npn_drive;
  assign switch_active_o = result_q.switch_active;
  assign raw_switch_o    = result_q.raw_switch;
  assign raw_toggle_o    = result_q.raw_toggle;
  assign power_on_done_o = result_q.power_on_done;

endmodule
